// File: hw/rtl/gcau_pkg.sv
// Shared types, constants and fixed-point helpers of the column accumulate unit.
package gcau_pkg;

   localparam int DATA_W    = 32;
   localparam int ROW_W     = 10;
   localparam int ROWS_W    = 11;
   localparam int CSR_IDX_W = 1;
   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 4;
   localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   localparam logic [DATA_W-1:0] ALPHA_RESET = 32'h0001_0000;
   localparam logic [ROWS_W-1:0] ROWS_RESET  = 11'd1024;
   localparam logic [DATA_W-1:0] SAT_MAX     = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] SAT_MIN     = 32'h8000_0000;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_ACCUM = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALPHA = 1'b0,
      CSR_ROWS  = 1'b1
   } csr_type;

   // operand is the load value for a load and the scaled x for an accumulate
   typedef struct packed {
      cmd_type           cmd;
      logic [ROW_W-1:0]  row;
      logic              last;
      logic [DATA_W-1:0] operand;
      logic [DATA_W-1:0] matrix;
   } work_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [ROW_W-1:0]  row;
      logic              last;
   } result_type;

   // Arithmetic shift right by 16 of a 64-bit product, clamped to 32 bits.
   function automatic logic [DATA_W-1:0] sat_shift16(input logic signed [63:0] p);
      logic [16:0] hi;
      hi = p[63:47];
      if (hi == 17'h0_0000 || hi == 17'h1_ffff) begin
         return p[47:16];
      end else if (p[63]) begin
         return SAT_MIN;
      end else begin
         return SAT_MAX;
      end
   endfunction

   function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
      logic [DATA_W:0] s;
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      if (s[DATA_W] != s[DATA_W-1]) begin
         return s[DATA_W] ? SAT_MIN : SAT_MAX;
      end
      return s[DATA_W-1:0];
   endfunction

endpackage

// File: hw/rtl/gcau_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gcau_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents when it meets a write to the same entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/gcau_fifo.sv
// Small register FIFO with an occupancy count.
module gcau_fifo #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   output logic [WIDTH-1:0]                 rd_data,
   output logic [$clog2(DEPTH + 1)-1:0]     count,
   output logic                             empty
);

   localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_rd;

   assign do_rd = rd_en && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && do_rd) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_data = mem[rd_ptr_ff];
   assign count   = count_ff;
   assign empty   = (count_ff == '0);

endmodule

// File: hw/rtl/gcau_front.sv
// Front end: takes requests, drops out-of-range rows and unknown commands, scales x by alpha.
module gcau_front
   import gcau_pkg::*;
#(
   parameter int ROWS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [DATA_W-1:0]    alpha,
   input  logic [ROWS_W-1:0]    rows,
   input  logic                 push,
   output logic                 full,
   input  logic [1:0]           command,
   input  logic [ROW_W-1:0]     row_index,
   input  logic [DATA_W-1:0]    matrix_value,
   input  logic [DATA_W-1:0]    vector_value,
   input  logic [DATA_W-1:0]    load_value,
   input  logic [MID_CNT_W-1:0] mid_count,
   output logic                 q_push,
   output work_type             q_data
);

   localparam logic [16:0]          ROWS_LIM = 17'(ROWS);
   localparam logic [MID_CNT_W:0]   MID_LIM  = (MID_CNT_W + 1)'(MID_DEPTH);

   logic               f1_valid_ff, f1_valid_in;
   work_type           f1_work_ff, f1_work_in;
   logic signed [63:0] f1_product_ff, f1_product_in;
   logic               accept;
   logic               row_ok;
   logic               cmd_ok;
   logic [MID_CNT_W:0] pending;

   // reserve a queue slot for the request held in the multiply stage
   assign pending = {1'b0, mid_count} + {{MID_CNT_W{1'b0}}, f1_valid_ff};
   assign full    = (pending >= MID_LIM);
   assign accept  = push && !full;
   assign row_ok  = (ROWS_W'(row_index) < rows) && (17'(row_index) < ROWS_LIM);
   assign cmd_ok  = command inside {CMD_LOAD, CMD_ACCUM, CMD_READ};

   always_comb begin
      f1_valid_in         = accept && row_ok && cmd_ok;
      f1_work_in.cmd      = cmd_type'(command);
      f1_work_in.row      = row_index;
      f1_work_in.last     = ((ROWS_W'(row_index) + 1'b1) == rows);
      f1_work_in.operand  = load_value;
      f1_work_in.matrix   = matrix_value;
      f1_product_in       = $signed(alpha) * $signed(vector_value);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= f1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f1_work_ff    <= f1_work_in;
         f1_product_ff <= f1_product_in;
      end
   end

   always_comb begin
      q_push = f1_valid_ff;
      q_data = f1_work_ff;
      if (f1_work_ff.cmd != CMD_LOAD) begin
         q_data.operand = sat_shift16(f1_product_ff);
      end
   end

`ifndef SYNTH
   a_mid_no_overflow: assert property (@(posedge clock) disable iff (reset)
      pending <= MID_LIM)
      else $error("mid queue overcommitted");
`endif

endmodule

// File: hw/rtl/gcau_back.sv
// Back end: multiply, read-modify-write of the y store with forwarding, results.
module gcau_back
   import gcau_pkg::*;
#(
   parameter int ROWS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  work_type             q_data,
   output logic                 q_pop,
   input  logic [OUT_CNT_W-1:0] out_count,
   output logic                 res_push,
   output result_type           res_data
);

   localparam int AW = ROWS > 1 ? $clog2(ROWS) : 1;
   localparam int XW = AW > ROW_W ? AW : ROW_W;
   localparam logic [OUT_CNT_W:0] OUT_LIM = (OUT_CNT_W + 1)'(OUT_DEPTH);

   logic               s1_valid_ff;
   work_type           s1_work_ff;
   logic signed [63:0] s1_product_ff;
   logic               s2_valid_ff;
   work_type           s2_work_ff;
   logic [DATA_W-1:0]  s2_prod_ff;
   logic               wb_valid_ff;
   logic [AW-1:0]      wb_addr_ff;
   logic [DATA_W-1:0]  wb_data_ff;

   logic [OUT_CNT_W:0] inflight;
   logic [XW-1:0]      s1_row_x;
   logic [XW-1:0]      s2_row_x;
   logic [AW-1:0]      s1_addr;
   logic [AW-1:0]      s2_addr;
   logic [DATA_W-1:0]  rd_data;
   logic [DATA_W-1:0]  old_value;
   logic [DATA_W-1:0]  new_value;
   logic               ram_wr_en;

   // pop only when every request in flight is sure of a result slot
   assign inflight = {1'b0, out_count} + {{OUT_CNT_W{1'b0}}, s1_valid_ff}
                   + {{OUT_CNT_W{1'b0}}, s2_valid_ff};
   assign q_pop    = !q_empty && (inflight < OUT_LIM);

   assign s1_row_x = XW'(s1_work_ff.row);
   assign s2_row_x = XW'(s2_work_ff.row);
   assign s1_addr  = s1_row_x[AW-1:0];
   assign s2_addr  = s2_row_x[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         wb_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= q_pop;
         s2_valid_ff <= s1_valid_ff;
         if (ram_wr_en) begin
            wb_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_work_ff    <= q_data;
         s1_product_ff <= $signed(q_data.operand) * $signed(q_data.matrix);
      end
      s2_work_ff <= s1_work_ff;
      s2_prod_ff <= sat_shift16(s1_product_ff);
      if (ram_wr_en) begin
         wb_addr_ff <= s2_addr;
         wb_data_ff <= new_value;
      end
   end

   gcau_ram #(
      .WIDTH (DATA_W),
      .DEPTH (ROWS)
   ) u_y_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s2_addr),
      .wr_data (new_value),
      .rd_en   (s1_valid_ff),
      .rd_addr (s1_addr),
      .rd_data (rd_data)
   );

   // the write of the previous request lands on the edge of this read: forward it
   always_comb begin
      old_value = (wb_valid_ff && wb_addr_ff == s2_addr) ? wb_data_ff : rd_data;
      case (s2_work_ff.cmd)
         CMD_LOAD:  new_value = s2_work_ff.operand;
         CMD_ACCUM: new_value = sat_add(old_value, s2_prod_ff);
         default:   new_value = old_value;
      endcase
      ram_wr_en      = s2_valid_ff && (s2_work_ff.cmd != CMD_READ);
      res_push       = s2_valid_ff && (s2_work_ff.cmd == CMD_READ);
      res_data.value = old_value;
      res_data.row   = s2_work_ff.row;
      res_data.last  = s2_work_ff.last;
   end

`ifndef SYNTH
   a_result_credit: assert property (@(posedge clock) disable iff (reset)
      inflight <= OUT_LIM)
      else $error("result queue overcommitted");

   a_stage_advance: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> $past(s1_valid_ff))
      else $error("write-back stage valid without a predecessor");

   a_write_or_result: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && res_push))
      else $error("store write and result in the same cycle");
`endif

endmodule

// File: hw/rtl/gemv_column_accumulate_unit.sv
// Top level of the column-ordered y += alpha*A*x accumulate unit.
//
//  channel   direction  handshake            payload
//  req_      in         req_push / req_full  command, row_index, matrix/vector/load value
//  rsp_      out        rsp_pop / rsp_empty  result_value, result_row, last_row
//  csr_      in         csr_write            csr_index, csr_data (no read-back)
//
// One request per cycle sustained while req_full is low; a read passes alpha multiply,
// queue and product multiply, store read and write-back before it shows on rsp_.
// Accumulates into the same row back to back are covered by forwarding the last store write.
// Synchronous active-high reset clears control state; the y store is not cleared.
// A stalled result side fills the result queue, then the mid queue, then raises req_full.
module gemv_column_accumulate_unit
   import gcau_pkg::*;
#(
   parameter int ROWS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [1:0]           req_command,
   input  logic [ROW_W-1:0]     req_row_index,
   input  logic signed [31:0]   req_matrix_value,
   input  logic signed [31:0]   req_vector_value,
   input  logic signed [31:0]   req_load_value,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic signed [31:0]   rsp_result_value,
   output logic [ROW_W-1:0]     rsp_result_row,
   output logic                 rsp_last_row,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_data
);

   logic [DATA_W-1:0]    alpha_ff;
   logic [ROWS_W-1:0]    rows_ff;
   logic                 q_push;
   work_type             q_wr_data;
   logic                 q_pop;
   logic [$bits(work_type)-1:0] q_rd_bits;
   logic [MID_CNT_W-1:0] mid_count;
   logic                 mid_empty;
   logic                 res_push;
   result_type           res_data;
   logic [$bits(result_type)-1:0] out_bits;
   result_type           out_data;
   logic [OUT_CNT_W-1:0] out_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
         rows_ff  <= ROWS_RESET;
      end else if (csr_write) begin
         case (csr_type'(csr_index))
            CSR_ALPHA: alpha_ff <= csr_data;
            CSR_ROWS:  rows_ff  <= csr_data[ROWS_W-1:0];
            default:   ;
         endcase
      end
   end

   gcau_front #(
      .ROWS (ROWS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .alpha        (alpha_ff),
      .rows         (rows_ff),
      .push         (req_push),
      .full         (req_full),
      .command      (req_command),
      .row_index    (req_row_index),
      .matrix_value (req_matrix_value),
      .vector_value (req_vector_value),
      .load_value   (req_load_value),
      .mid_count    (mid_count),
      .q_push       (q_push),
      .q_data       (q_wr_data)
   );

   gcau_fifo #(
      .WIDTH ($bits(work_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wr_data),
      .rd_en   (q_pop),
      .rd_data (q_rd_bits),
      .count   (mid_count),
      .empty   (mid_empty)
   );

   gcau_back #(
      .ROWS (ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (mid_empty),
      .q_data    (work_type'(q_rd_bits)),
      .q_pop     (q_pop),
      .out_count (out_count),
      .res_push  (res_push),
      .res_data  (res_data)
   );

   gcau_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_push),
      .wr_data (res_data),
      .rd_en   (rsp_pop),
      .rd_data (out_bits),
      .count   (out_count),
      .empty   (rsp_empty)
   );

   assign out_data         = result_type'(out_bits);
   assign rsp_result_value = $signed(out_data.value);
   assign rsp_result_row   = out_data.row;
   assign rsp_last_row     = out_data.last;

endmodule
